@@ design/bsum_pkg.sv @@
`default_nettype none

package bsum_pkg;

   // Result field widths
   localparam int SUM_BITS = 20;

   // Configuration register widths and layout
   localparam int ROW_CNT_BITS  = 16;
   localparam int COL_CNT_BITS  = 10;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes, taken from paddr bit 2
   localparam logic REG_ROW_COUNT    = 1'b0;
   localparam logic REG_COLUMN_COUNT = 1'b1;

   // Queue between front and back
   localparam int Q_DEPTH      = 4;
   localparam int Q_PTR_BITS   = 2;
   localparam int Q_LEVEL_BITS = 3;

   // Position class of one element, worked out by the front
   typedef struct packed {
      logic has_up1;    // a row above exists in this frame
      logic has_up2;    // two rows above exist
      logic first_col;  // leftmost column
      logic last_col;   // rightmost column
      logic last_row;   // bottom row
   } bsum_flags_type;

endpackage

`default_nettype wire

@@ design/bsum_if.sv @@
`default_nettype none

// Element channel
interface bsum_req_if #(
   parameter int ELEMENT_BITS = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [ELEMENT_BITS-1:0] element;

   modport source (output valid, output element, input ready);
   modport sink   (input valid, input element, output ready);
endinterface

// Result channel
interface bsum_rsp_if
   import bsum_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SUM_BITS-1:0] neighbourhood_sum;
   logic                       last_of_run;
   logic                       end_of_frame;

   modport source (output valid, output neighbourhood_sum, output last_of_run,
                   output end_of_frame, input ready);
   modport sink   (input valid, input neighbourhood_sum, input last_of_run,
                   input end_of_frame, output ready);
endinterface

`default_nettype wire

@@ design/bsum_ram.sv @@
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
// A read at the address being written returns the old contents.
module bsum_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ design/bsum_front.sv @@
`default_nettype none

// Front: register port, frame position, line stores.
// Stage A accepts an element and reads both line stores at its column;
// stage B has the store data, masks rows above the frame and pushes
// {two rows up, one row up, element} with its position class.
module bsum_front
   import bsum_pkg::*;
#(
   parameter int MAX_COLUMNS  = 512,
   parameter int ELEMENT_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // register port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]       csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0]       csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0]       csr_prdata,
   // element channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [ELEMENT_BITS-1:0] req_element,
   // queue side
   input  wire logic [Q_LEVEL_BITS-1:0]        q_level,
   output logic                                push_valid,
   output logic      [3*ELEMENT_BITS-1:0]      push_data,
   output bsum_flags_type                      push_flags
);

   localparam int COL_BITS = $clog2(MAX_COLUMNS);
   localparam int CMP_BITS = (COL_BITS + 1 > COL_CNT_BITS) ? COL_BITS + 1 : COL_CNT_BITS;

   // Registers
   logic [ROW_CNT_BITS-1:0] row_count_ff, row_count_in;
   logic [COL_CNT_BITS-1:0] column_count_ff, column_count_in;
   logic [ROW_CNT_BITS-1:0] row_pos_ff, row_pos_in;
   logic [COL_BITS-1:0]     col_pos_ff, col_pos_in;

   logic                           b_valid_ff, b_valid_in;
   logic signed [ELEMENT_BITS-1:0] b_x_ff;
   logic [COL_BITS-1:0]            b_col_ff;
   bsum_flags_type                 b_flags_ff;
   logic                           byp_hit_ff;
   logic [ELEMENT_BITS-1:0]        byp_data_ff;

   logic                    csr_write;
   logic                    reg_index;
   logic [CMP_BITS-1:0]     col_cnt_ext, cols_eff, cols_last;
   logic [ROW_CNT_BITS-1:0] rows_last;
   logic                    out_of_range;
   logic [ROW_CNT_BITS-1:0] row_sel;
   logic [COL_BITS-1:0]     col_sel;
   bsum_flags_type          flags;
   logic                    accept;
   logic                    byp_hit;
   logic [Q_LEVEL_BITS:0]   in_flight;

   logic [ELEMENT_BITS-1:0] newer_rd, older_rd;
   logic [ELEMENT_BITS-1:0] older_val;
   logic [ELEMENT_BITS-1:0] above1, above2;

   // Register decode
   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   assign reg_index = csr_paddr[CSR_ADDR_BITS-1];

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_write) begin
         case (reg_index)
            REG_ROW_COUNT:    row_count_in    = csr_pwdata[ROW_CNT_BITS-1:0];
            REG_COLUMN_COUNT: column_count_in = csr_pwdata[COL_CNT_BITS-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ROW_COUNT:    csr_prdata = CSR_DATA_BITS'(row_count_ff);
         REG_COLUMN_COUNT: csr_prdata = CSR_DATA_BITS'(column_count_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Effective frame size: zero counts as one, columns capped at store depth
   assign col_cnt_ext = CMP_BITS'(column_count_ff);
   assign cols_eff    = (col_cnt_ext == '0) ? CMP_BITS'(1) :
                        (col_cnt_ext > CMP_BITS'(MAX_COLUMNS)) ? CMP_BITS'(MAX_COLUMNS) :
                        col_cnt_ext;
   assign cols_last   = cols_eff - CMP_BITS'(1);
   assign rows_last   = (row_count_ff == '0) ? '0 : row_count_ff - ROW_CNT_BITS'(1);

   // Current position, restarted if it lies outside the frame
   assign out_of_range = (row_pos_ff > rows_last) || (CMP_BITS'(col_pos_ff) > cols_last);
   assign row_sel      = out_of_range ? '0 : row_pos_ff;
   assign col_sel      = out_of_range ? '0 : col_pos_ff;

   assign flags.has_up1   = (row_sel != '0);
   assign flags.has_up2   = (row_sel[ROW_CNT_BITS-1:1] != '0);
   assign flags.first_col = (col_sel == '0);
   assign flags.last_col  = (CMP_BITS'(col_sel) == cols_last);
   assign flags.last_row  = (row_sel == rows_last);

   // Room check: queue entries plus the beat in stage B
   assign in_flight = (Q_LEVEL_BITS + 1)'(q_level) + (Q_LEVEL_BITS + 1)'(b_valid_ff);
   assign req_ready = (in_flight < (Q_LEVEL_BITS + 1)'(Q_DEPTH));
   assign accept    = req_valid & req_ready;

   // Raster position step
   always_comb begin
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      if (csr_write) begin
         row_pos_in = '0;
         col_pos_in = '0;
      end else if (accept) begin
         if (flags.last_col) begin
            col_pos_in = '0;
            row_pos_in = flags.last_row ? '0 : row_sel + ROW_CNT_BITS'(1);
         end else begin
            row_pos_in = row_sel;
            col_pos_in = col_sel + COL_BITS'(1);
         end
      end
   end

   // Line stores: newer is written at accept, older gets the old newer
   // entry in the following cycle from stage B
   bsum_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (MAX_COLUMNS)
   ) u_newer_store (
      .clock      (clock),
      .wr_en      (accept),
      .wr_addr    (col_sel),
      .wr_data    (req_element),
      .rd_addr    (col_sel),
      .rd_data_ff (newer_rd)
   );

   bsum_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (MAX_COLUMNS)
   ) u_older_store (
      .clock      (clock),
      .wr_en      (b_valid_ff),
      .wr_addr    (b_col_ff),
      .wr_data    (newer_rd),
      .rd_addr    (col_sel),
      .rd_data_ff (older_rd)
   );

   // Forward the older-store write when the next beat reads the same column
   assign byp_hit = b_valid_ff && (b_col_ff == col_sel);

   assign b_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_CNT_BITS'(1);
         column_count_ff <= COL_CNT_BITS'(1);
         row_pos_ff      <= '0;
         col_pos_ff      <= '0;
         b_valid_ff      <= 1'b0;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         row_pos_ff      <= row_pos_in;
         col_pos_ff      <= col_pos_in;
         b_valid_ff      <= b_valid_in;
      end
      b_x_ff      <= req_element;
      b_col_ff    <= col_sel;
      b_flags_ff  <= flags;
      byp_hit_ff  <= byp_hit;
      byp_data_ff <= newer_rd;
   end

   // Stage B: mask rows above the frame top
   assign older_val = byp_hit_ff ? byp_data_ff : older_rd;
   assign above2    = b_flags_ff.has_up2 ? older_val : '0;
   assign above1    = b_flags_ff.has_up1 ? newer_rd : '0;

   assign push_valid = b_valid_ff;
   assign push_data  = {above2, above1, b_x_ff};
   assign push_flags = b_flags_ff;

endmodule

`default_nettype wire

@@ design/bsum_queue.sv @@
`default_nettype none

// Short FIFO between front and back. The front only pushes when it
// has counted room, so there is no full check here.
module bsum_queue
   import bsum_pkg::*;
#(
   parameter int DATA_BITS = 48
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   input  wire logic [DATA_BITS-1:0]    push_data,
   input  wire bsum_flags_type          push_flags,
   output logic      [Q_LEVEL_BITS-1:0] level,
   input  wire logic                    pop,
   output logic                         head_valid,
   output logic      [DATA_BITS-1:0]    head_data,
   output bsum_flags_type               head_flags
);

   logic [DATA_BITS-1:0]    data_ff  [Q_DEPTH];
   bsum_flags_type          flags_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_LEVEL_BITS-1:0] level_ff, level_in;
   logic                    do_pop;

   assign do_pop = pop & head_valid;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + Q_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_PTR_BITS'(1) : rd_ptr_ff;
      level_in  = level_ff + Q_LEVEL_BITS'(push_valid) - Q_LEVEL_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push_valid) begin
         data_ff[wr_ptr_ff]  <= push_data;
         flags_ff[wr_ptr_ff] <= push_flags;
      end
   end

   assign level      = level_ff;
   assign head_valid = (level_ff != '0);
   assign head_data  = data_ff[rd_ptr_ff];
   assign head_flags = flags_ff[rd_ptr_ff];

endmodule

`default_nettype wire

@@ design/bsum_back.sv @@
`default_nettype none

// Back: 3-column window of column sums and the result register.
// Each window column holds the full 3-row sum and the lower 2-row sum.
// A popped beat shifts the window and sets up to four pending results,
// which leave one per cycle through the result register while the receiver is ready.
module bsum_back
   import bsum_pkg::*;
#(
   parameter int ELEMENT_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        head_valid,
   input  wire logic [3*ELEMENT_BITS-1:0]   head_data,
   input  wire bsum_flags_type              head_flags,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [SUM_BITS-1:0]       rsp_sum,
   output logic                             rsp_last,
   output logic                             rsp_eof
);

   localparam int COL_SUM_BITS = ELEMENT_BITS + 2;
   localparam int ACC_BITS     = (ELEMENT_BITS + 4 > SUM_BITS) ? ELEMENT_BITS + 4 : SUM_BITS;

   // Pending result kinds, in output order
   localparam int KIND_FULL   = 0;  // row above, column left
   localparam int KIND_RIGHT  = 1;  // row above, this column, right edge
   localparam int KIND_BOTTOM = 2;  // this row, column left, bottom edge
   localparam int KIND_CORNER = 3;  // this row, this column, bottom right
   localparam int KINDS       = 4;

   logic signed [COL_SUM_BITS-1:0] full_ff [3];
   logic signed [COL_SUM_BITS-1:0] low_ff  [3];
   logic [KINDS-1:0]               pend_ff, pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_BITS-1:0]     rsp_sum_ff, rsp_sum_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_eof_ff, rsp_eof_in;

   logic signed [ELEMENT_BITS-1:0] new_x, new_a1, new_a2;
   logic signed [COL_SUM_BITS-1:0] new_full, new_low;
   logic [KINDS-1:0]               new_mask;
   logic [KINDS-1:0]               pick;
   logic [KINDS-1:0]               pend_rest;
   logic                           slot_free;
   logic                           emit;
   logic                           use_low, with_left;
   logic signed [COL_SUM_BITS-1:0] term0, term1, term2;
   logic signed [ACC_BITS-1:0]     acc;

   // Incoming column
   assign new_x    = head_data[ELEMENT_BITS-1:0];
   assign new_a1   = head_data[2*ELEMENT_BITS-1:ELEMENT_BITS];
   assign new_a2   = head_data[3*ELEMENT_BITS-1:2*ELEMENT_BITS];
   assign new_low  = COL_SUM_BITS'(new_a1) + COL_SUM_BITS'(new_x);
   assign new_full = COL_SUM_BITS'(new_a2) + new_low;

   always_comb begin
      new_mask              = '0;
      new_mask[KIND_FULL]   = head_flags.has_up1 & ~head_flags.first_col;
      new_mask[KIND_RIGHT]  = head_flags.has_up1 & head_flags.last_col;
      new_mask[KIND_BOTTOM] = head_flags.last_row & ~head_flags.first_col;
      new_mask[KIND_CORNER] = head_flags.last_row & head_flags.last_col;
   end

   // Lowest pending kind goes first
   always_comb begin
      pick = '0;
      if (pend_ff[KIND_FULL]) begin
         pick[KIND_FULL] = 1'b1;
      end else if (pend_ff[KIND_RIGHT]) begin
         pick[KIND_RIGHT] = 1'b1;
      end else if (pend_ff[KIND_BOTTOM]) begin
         pick[KIND_BOTTOM] = 1'b1;
      end else if (pend_ff[KIND_CORNER]) begin
         pick[KIND_CORNER] = 1'b1;
      end
   end

   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign emit      = slot_free & (pend_ff != '0);
   assign pend_rest = emit ? (pend_ff & ~pick) : pend_ff;
   // Window may move once the current beat's results are all out
   assign pop       = head_valid & (pend_rest == '0);
   assign pend_in   = pop ? new_mask : pend_rest;

   // Sum of the selected window part
   assign use_low   = pick[KIND_BOTTOM] | pick[KIND_CORNER];
   assign with_left = pick[KIND_FULL] | pick[KIND_BOTTOM];
   assign term0     = with_left ? (use_low ? low_ff[0] : full_ff[0]) : '0;
   assign term1     = use_low ? low_ff[1] : full_ff[1];
   assign term2     = use_low ? low_ff[2] : full_ff[2];
   assign acc       = ACC_BITS'(term0) + ACC_BITS'(term1) + ACC_BITS'(term2);

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_eof_in   = rsp_eof_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = acc[SUM_BITS-1:0];
         rsp_last_in  = (pend_rest == '0);
         rsp_eof_in   = pick[KIND_CORNER];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sum_ff  <= rsp_sum_in;
      rsp_last_ff <= rsp_last_in;
      rsp_eof_ff  <= rsp_eof_in;
      // Window shift; left columns clear at the start of a row
      if (pop) begin
         if (head_flags.first_col) begin
            full_ff[0] <= '0;
            full_ff[1] <= '0;
            low_ff[0]  <= '0;
            low_ff[1]  <= '0;
         end else begin
            full_ff[0] <= full_ff[1];
            full_ff[1] <= full_ff[2];
            low_ff[0]  <= low_ff[1];
            low_ff[1]  <= low_ff[2];
         end
         full_ff[2] <= new_full;
         low_ff[2]  <= new_low;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = rsp_sum_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_eof   = rsp_eof_ff;

endmodule

`default_nettype wire

@@ design/box_sum_3x3_zero_border.sv @@
`default_nettype none

// 3x3 box sum over a matrix streamed in raster order, with zero border.
// Each beat on req carries one element; rsp carries the 20-bit sum of an
// element and its eight neighbours, last_of_run on the final result caused
// by an input beat, and end_of_frame on the bottom-right result. Results
// lag by one row and one column; the bottom row's results come out along
// with its elements, so one element may cause up to four results. Registers:
// row_count at byte address 0, column_count at 4 (capped at MAX_COLUMNS);
// a write restarts the frame and may only be made while the block is idle.
// An element is taken every cycle as long as the results keep up: the single
// result register sends one result per cycle while the receiver is ready, and an
// element yields at most two results, except four at the right end of the bottom
// row. An element's results pass through stage B (store read), the queue, the
// pending-result flags and the result register. Line stores are two
// MAX_COLUMNS x ELEMENT_BITS RAMs.
module box_sum_3x3_zero_border
   import bsum_pkg::*;
#(
   parameter int MAX_COLUMNS  = 512,
   parameter int ELEMENT_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   bsum_req_if.sink                      req,
   bsum_rsp_if.source                    rsp,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   localparam int DATA_BITS = 3 * ELEMENT_BITS;

   logic                    push_valid;
   logic [DATA_BITS-1:0]    push_data;
   bsum_flags_type          push_flags;
   logic [Q_LEVEL_BITS-1:0] q_level;
   logic                    pop;
   logic                    head_valid;
   logic [DATA_BITS-1:0]    head_data;
   bsum_flags_type          head_flags;

   assign csr_pready = 1'b1;

   bsum_front #(
      .MAX_COLUMNS  (MAX_COLUMNS),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .req_element (req.element),
      .q_level     (q_level),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .push_flags  (push_flags)
   );

   bsum_queue #(
      .DATA_BITS (DATA_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_flags (push_flags),
      .level      (q_level),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_flags (head_flags)
   );

   bsum_back #(
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_flags (head_flags),
      .pop        (pop),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_sum    (rsp.neighbourhood_sum),
      .rsp_last   (rsp.last_of_run),
      .rsp_eof    (rsp.end_of_frame)
   );

endmodule

`default_nettype wire

@@ design/bsum_checker.sv @@
`default_nettype none

// Port-level checks on the result channel
module bsum_checker
   import bsum_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [SUM_BITS-1:0] rsp_sum,
   input wire logic                rsp_last,
   input wire logic                rsp_eof
);

   // No result directly after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_sum) && $stable(rsp_last) && $stable(rsp_eof))
      else $error("stalled result changed");

   // Bottom-right result always closes its run
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_eof |-> rsp_last)
      else $error("end of frame without last of run");

   // A run continues without a gap
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a run of results");

endmodule

bind box_sum_3x3_zero_border bsum_checker u_bsum_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_sum   (rsp.neighbourhood_sum),
   .rsp_last  (rsp.last_of_run),
   .rsp_eof   (rsp.end_of_frame)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking bench for box_sum_3x3_zero_border: elements stream in, every sum beat
// is checked against an in-bench window model or, for typed plan rows, a given sum.
module tb_top
   import bsum_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ELEM_BITS = 16;
   localparam int MAX_COLS  = 512;
   localparam int RUN_LIMIT = 400000;
   localparam int PIPE_FLUSH = 8;

   // One expected sum beat
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      logic                       last;
      logic                       eof;
   } box_result_type;

   // Directed plan rows
   typedef enum logic [1:0] {DO_WRITE, DO_READ, DO_ELEMENT} plan_op_type;

   typedef struct packed {
      plan_op_type op;
      logic        reg_sel;
      int          value;
      int          count;
      bit          typed;
      int          want;
   } plan_row_type;

   localparam int PLAN_ROWS = 12;
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // reset values read back, 1x1 frames after reset
      '{DO_READ,    REG_ROW_COUNT,    0,      0, 1'b1, 1},
      '{DO_READ,    REG_COLUMN_COUNT, 0,      0, 1'b1, 1},
      '{DO_ELEMENT, REG_ROW_COUNT,    5,      1, 1'b1, 5},
      '{DO_ELEMENT, REG_ROW_COUNT,    32767,  1, 1'b1, 32767},
      '{DO_ELEMENT, REG_ROW_COUNT,    -32768, 1, 1'b1, -32768},
      // zero counts behave as one
      '{DO_WRITE,   REG_ROW_COUNT,    0,      0, 1'b0, 0},
      '{DO_WRITE,   REG_COLUMN_COUNT, 0,      0, 1'b0, 0},
      '{DO_ELEMENT, REG_ROW_COUNT,    -1,     1, 1'b1, -1},
      // 3x3 frames at both extremes: largest and smallest sums
      '{DO_WRITE,   REG_ROW_COUNT,    3,      0, 1'b0, 0},
      '{DO_WRITE,   REG_COLUMN_COUNT, 3,      0, 1'b0, 0},
      '{DO_ELEMENT, REG_ROW_COUNT,    32767,  9, 1'b0, 0},
      '{DO_ELEMENT, REG_ROW_COUNT,    -32768, 9, 1'b0, 0}
   };

   logic clock = 1'b0;
   logic reset;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   bsum_req_if #(.ELEMENT_BITS(ELEM_BITS)) req_bus ();
   bsum_rsp_if                              rsp_bus ();

   box_sum_3x3_zero_border #(
      .MAX_COLUMNS (MAX_COLS),
      .ELEMENT_BITS(ELEM_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Window model state
   logic signed [ELEM_BITS-1:0] line_older [MAX_COLS];
   logic signed [ELEM_BITS-1:0] line_newer [MAX_COLS];
   int                          win [9];
   int                          row_pos;
   int                          col_pos;
   logic [ROW_CNT_BITS-1:0]     cfg_rows;
   logic [COL_CNT_BITS-1:0]     cfg_cols;

   box_result_type step_sums[$];
   box_result_type sums_pending[$];

   int mismatch_count;
   int results_seen;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   bit hold_off_req;

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("tb_top: mismatch: %s", what);
   endtask

   function automatic int window_sum(input int row_lo, input int col_lo);
      int s;
      s = 0;
      for (int i = row_lo; i < 3; i++)
         for (int j = col_lo; j < 3; j++)
            s += win[i*3 + j];
      return s;
   endfunction

   function automatic void push_sum(input int s, input logic eof);
      box_result_type res;
      res.sum  = s[SUM_BITS-1:0];
      res.last = 1'b0;
      res.eof  = eof;
      step_sums.push_back(res);
   endfunction

   // Advance the window by one element; the sums it releases land in step_sums
   function automatic void step_box(input logic signed [ELEM_BITS-1:0] x);
      int rows, cols, r, c, up2, up1;
      rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
      cols = (cfg_cols == 0) ? 1 : ((int'(cfg_cols) > MAX_COLS) ? MAX_COLS : int'(cfg_cols));
      r = row_pos;
      c = col_pos;
      step_sums.delete();
      if (r >= rows || c >= cols) begin
         r = 0;
         c = 0;
      end
      up2 = (r >= 2) ? int'(line_older[c]) : 0;
      up1 = (r >= 1) ? int'(line_newer[c]) : 0;

      // shift left, or clear at the start of a row
      for (int i = 0; i < 3; i++) begin
         win[i*3 + 0] = (c == 0) ? 0 : win[i*3 + 1];
         win[i*3 + 1] = (c == 0) ? 0 : win[i*3 + 2];
      end
      win[2] = up2;
      win[5] = up1;
      win[8] = int'(x);
      line_older[c] = line_newer[c];
      line_newer[c] = x;

      // row above, then the bottom row itself
      if (r >= 1) begin
         if (c >= 1)
            push_sum(window_sum(0, 0), 1'b0);
         if (c == cols - 1)
            push_sum(window_sum(0, 1), 1'b0);
      end
      if (r == rows - 1) begin
         if (c >= 1)
            push_sum(window_sum(1, 0), 1'b0);
         if (c == cols - 1)
            push_sum(window_sum(1, 1), 1'b1);
      end
      if (step_sums.size() > 0)
         step_sums[step_sums.size() - 1].last = 1'b1;

      c++;
      if (c >= cols) begin
         c = 0;
         r++;
         if (r >= rows)
            r = 0;
      end
      row_pos = r;
      col_pos = c;
   endfunction

   function automatic int pick_gap(input int pct);
      int g;
      g = 0;
      while (g < 30 && $urandom_range(0, 99) < pct)
         g++;
      return g;
   endfunction

   function automatic logic signed [ELEM_BITS-1:0] pick_element();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return ELEM_BITS'($urandom);
      endcase
   endfunction

   // One element beat; typed rows replace the model's sum with the given one
   task automatic send_element(input logic signed [ELEM_BITS-1:0] v, input bit typed,
                               input int want);
      int gap;
      box_result_type res;
      gap = pick_gap(send_idle_pct);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.element <= v;
      do @(posedge clock); while (!req_bus.ready);
      step_box(v);
      if (typed) begin
         res.sum  = want[SUM_BITS-1:0];
         res.last = 1'b1;
         res.eof  = 1'b1;
         sums_pending.push_back(res);
      end else begin
         foreach (step_sums[i])
            sums_pending.push_back(step_sums[i]);
      end
   endtask

   // Stop sending and let every expected sum and any sum-less beat drain
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (sums_pending.size() != 0)
         @(posedge clock);
      repeat (PIPE_FLUSH) @(posedge clock);
   endtask

   task automatic csr_read(input logic reg_sel, output logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {reg_sel, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Register write, model update and read-back of in-range values
   task automatic csr_write(input logic reg_sel, input int unsigned value);
      logic [CSR_DATA_BITS-1:0] back;
      bit in_range;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == REG_ROW_COUNT) begin
         cfg_rows = value[ROW_CNT_BITS-1:0];
         in_range = value >= 1 && value <= 65535;
      end else begin
         cfg_cols = value[COL_CNT_BITS-1:0];
         in_range = value >= 1 && value <= MAX_COLS;
      end
      row_pos = 0;
      col_pos = 0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_read(reg_sel, back);
      if (in_range && back != value)
         flag_mismatch($sformatf("register %0d read %0d, wrote %0d", reg_sel, back, value));
   endtask

   task automatic set_frame(input int unsigned rows, input int unsigned cols);
      wait_idle();
      csr_write(REG_ROW_COUNT, rows);
      csr_write(REG_COLUMN_COUNT, cols);
   endtask

   // Sum beat checker
   always @(posedge clock) begin : sum_check
      box_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (sums_pending.size() == 0) begin
            flag_mismatch($sformatf("sum beat %0d unexpected: %0d", results_seen,
                                    rsp_bus.neighbourhood_sum));
         end else begin
            want = sums_pending.pop_front();
            if (rsp_bus.neighbourhood_sum !== want.sum)
               flag_mismatch($sformatf("sum beat %0d: sum %0d, want %0d", results_seen,
                                       rsp_bus.neighbourhood_sum, want.sum));
            if (rsp_bus.last_of_run !== want.last)
               flag_mismatch($sformatf("sum beat %0d: last_of_run %b, want %b",
                                       results_seen, rsp_bus.last_of_run, want.last));
            if (rsp_bus.end_of_frame !== want.eof)
               flag_mismatch($sformatf("sum beat %0d: end_of_frame %b, want %b",
                                       results_seen, rsp_bus.end_of_frame, want.eof));
         end
      end
   end

   // Sum receiver: random backpressure, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_req) begin
         hold_left = 150;
         hold_off_req <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0] got;
      int quota, rows, cols, n, frames;
      bit partial, stall_done;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.element = '0;
      rsp_bus.ready   = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      cfg_rows        = 1;
      cfg_cols        = 1;
      row_pos         = 0;
      col_pos         = 0;
      mismatch_count  = 0;
      results_seen    = 0;
      hold_left       = 0;
      hold_off_req    = 1'b0;
      send_idle_pct   = 28;
      recv_idle_pct   = 64;
      stall_done      = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed plan
      foreach (DIRECTED_PLAN[k]) begin
         case (DIRECTED_PLAN[k].op)
            DO_READ: begin
               csr_read(DIRECTED_PLAN[k].reg_sel, got);
               if (got != DIRECTED_PLAN[k].want)
                  flag_mismatch($sformatf("register %0d read %0d, want %0d",
                                          DIRECTED_PLAN[k].reg_sel, got,
                                          DIRECTED_PLAN[k].want));
            end
            DO_WRITE: begin
               wait_idle();
               csr_write(DIRECTED_PLAN[k].reg_sel, DIRECTED_PLAN[k].value);
            end
            default: begin
               repeat (DIRECTED_PLAN[k].count)
                  send_element(ELEM_BITS'(DIRECTED_PLAN[k].value), DIRECTED_PLAN[k].typed,
                               DIRECTED_PLAN[k].want);
            end
         endcase
      end

      // Random frames, three backpressure mixes
      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct <= 64;
               // column count past the line store depth, cut short
               set_frame(1, 1023);
               repeat (30) send_element(pick_element(), 1'b0, 0);
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct <= 28;
               // tallest frame, cut short by the next write
               set_frame(65535, 1);
               repeat (40) send_element(pick_element(), 1'b0, 0);
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
               // widest in-range row, cut short
               set_frame(1, MAX_COLS);
               repeat (30) send_element(pick_element(), 1'b0, 0);
            end
         endcase

         quota = 95;
         while (quota > 0) begin
            if ($urandom_range(0, 5) == 0) begin
               rows = $urandom_range(1, 3);
               cols = $urandom_range(9, 48);
            end else begin
               rows = $urandom_range(1, 6);
               cols = $urandom_range(1, 8);
            end
            set_frame(rows, cols);
            frames = $urandom_range(1, 3);
            partial = 1'b0;
            for (int f = 0; f < frames && !partial; f++) begin
               n = rows * cols;
               if ($urandom_range(0, 5) == 0) begin
                  n = $urandom_range(1, n);
                  partial = 1'b1;
               end
               repeat (n) begin
                  send_element(pick_element(), 1'b0, 0);
                  quota--;
                  // fill the block against a stalled receiver
                  if (phase == 2 && !stall_done && quota <= 60) begin
                     hold_off_req <= 1'b1;
                     stall_done = 1'b1;
                  end
               end
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0 && sums_pending.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

@@ box_sum_3x3_zero_border.f @@
design/bsum_pkg.sv
design/bsum_if.sv
design/bsum_ram.sv
design/bsum_front.sv
design/bsum_queue.sv
design/bsum_back.sv
design/box_sum_3x3_zero_border.sv
design/bsum_checker.sv
tb/tb_top.sv
